// ===== rtl/keyed_token_bucket_limiter_core_assert.svh =====
// Assertion helpers shared by the limiter RTL.
`ifndef KEYED_TOKEN_BUCKET_LIMITER_CORE_ASSERT_SVH
`define KEYED_TOKEN_BUCKET_LIMITER_CORE_ASSERT_SVH

// Same-cycle implication.
`define KTBL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ktbl assertion failed");

// Next-cycle implication.
`define KTBL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ktbl assertion failed");

`endif

// ===== rtl/ktbl_pkg.sv =====
package ktbl_pkg;

   localparam int OP_W     = 2;
   localparam int ACT_W    = 6;
   localparam int WORD_W   = 32;
   localparam int STATUS_W = 3;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [2*WORD_W-1:0] dword_type;

   typedef enum logic [OP_W-1:0] {
      OP_CONSUME   = 2'd0,
      OP_CLEAR_ONE = 2'd1,
      OP_CLEAR_ALL = 2'd2,
      OP_RESERVED  = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK           = 3'd0,
      ST_NO_AUTH      = 3'd1,
      ST_BAD_ACTION   = 3'd2,
      ST_BAD_SETTINGS = 3'd3,
      ST_LIMITED      = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_MUL,
      S_SUM,
      S_FIN
   } state_type;

   typedef struct packed {
      logic load_req;
      logic calc_elapsed;
      logic calc_product;
      logic calc_sum;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic refill_path;
      logic rsp_free;
   } sts_type;

endpackage

// ===== rtl/ktbl_if.sv =====
interface ktbl_req_if;
   import ktbl_pkg::*;
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [ACT_W-1:0]  action_id;
   logic [WORD_W-1:0] now_tick;
   logic [WORD_W-1:0] refill_rate;
   logic [WORD_W-1:0] burst_capacity;
   logic [WORD_W-1:0] cost;

   modport source (output valid, output operation, output action_id, output now_tick,
                   output refill_rate, output burst_capacity, output cost, input ready);
   modport sink   (input valid, input operation, input action_id, input now_tick,
                   input refill_rate, input burst_capacity, input cost, output ready);
endinterface

interface ktbl_rsp_if;
   import ktbl_pkg::*;
   logic                valid;
   logic                ready;
   logic                granted;
   logic [STATUS_W-1:0] status;
   logic [WORD_W-1:0]   tokens_left;

   modport source (output valid, output granted, output status, output tokens_left,
                   input ready);
   modport sink   (input valid, input granted, input status, input tokens_left,
                   output ready);
endinterface

interface ktbl_csr_if;
   logic valid;
   logic ready;
   logic has_authority;

   modport source (output valid, output has_authority, input ready);
   modport sink   (input valid, input has_authority, output ready);
endinterface

// ===== rtl/keyed_token_bucket_limiter_core.sv =====
// Keyed token bucket limiter.
// req_bus carries one request per handshake (valid && ready): an operation
// (consume, clear one bucket, clear all), an action index, the current tick,
// the Q16.16 refill rate, burst capacity and cost. rsp_bus returns exactly one
// response per request, in order: granted, status and the bucket level left.
// csr_bus writes the authority bit; it is always ready. The user must write it
// only while no request is in flight; the block does not enforce this.
// A request is taken in the idle state and the bucket entry is read from a
// registered table; the response register loads in the final state. Clears,
// rejects and new buckets go there straight from the evaluate state; a refill
// of an existing bucket first passes the multiply and sum states (registered
// read, 32x32 multiply of elapsed ticks by rate, 64-bit saturating add, then
// deduct and write back). A new request is taken only after the last one ends.
// The response register decouples the sides: a new request is accepted while
// a response waits; if rsp_bus stays stalled, the next request finishes its
// work and holds in its last step until the response register frees.
// Reset (synchronous) empties all buckets and sets authority; level and tick
// storage is not cleared, so the block is ready as soon as reset is released.
module keyed_token_bucket_limiter_core #(
   parameter int NUM_ACTIONS = 64,
   parameter int FRAC_BITS   = 16
) (
   input  logic       clock,
   input  logic       reset,
   ktbl_req_if.sink   req_bus,
   ktbl_rsp_if.source rsp_bus,
   ktbl_csr_if.sink   csr_bus
);
   import ktbl_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    req_ready;

   assign req_bus.ready = req_ready;

   ktbl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ktbl_datapath #(
      .NUM_ACTIONS (NUM_ACTIONS),
      .FRAC_BITS   (FRAC_BITS)
   ) u_datapath (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus),
      .cmd   (cmd),
      .sts   (sts)
   );

endmodule

// ===== rtl/ktbl_ctrl.sv =====
`include "keyed_token_bucket_limiter_core_assert.svh"

module ktbl_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ktbl_pkg::sts_type sts,
   output ktbl_pkg::cmd_type cmd
);
   import ktbl_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EVAL;
         end
         S_EVAL: begin
            state_in = sts.refill_path ? S_MUL : S_FIN;
         end
         S_MUL: begin
            state_in = S_SUM;
         end
         S_SUM: begin
            state_in = S_FIN;
         end
         S_FIN: begin
            if (sts.rsp_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready        = 1'b0;
      cmd              = '0;
      case (state_ff)
         S_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         S_EVAL: begin
            cmd.calc_elapsed = 1'b1;
         end
         S_MUL: begin
            cmd.calc_product = 1'b1;
         end
         S_SUM: begin
            cmd.calc_sum = 1'b1;
         end
         S_FIN: begin
            cmd.finish = sts.rsp_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   `KTBL_ASSERT_NEXT(a_accept_to_eval, clock, reset,
                     state_ff == S_IDLE && req_valid, state_ff == S_EVAL)
   `KTBL_ASSERT_NEXT(a_mul_to_sum, clock, reset, state_ff == S_MUL, state_ff == S_SUM)
   `KTBL_ASSERT_NEXT(a_fin_holds, clock, reset,
                     state_ff == S_FIN && !sts.rsp_free, state_ff == S_FIN)

endmodule

// ===== rtl/ktbl_datapath.sv =====
`include "keyed_token_bucket_limiter_core_assert.svh"

module ktbl_datapath #(
   parameter int NUM_ACTIONS = 64,
   parameter int FRAC_BITS   = 16
) (
   input  logic              clock,
   input  logic              reset,
   ktbl_req_if.sink          req,
   ktbl_rsp_if.source        rsp,
   ktbl_csr_if.sink          csr,
   input  ktbl_pkg::cmd_type cmd,
   output ktbl_pkg::sts_type sts
);
   import ktbl_pkg::*;

   localparam int ACT_SPAN = 1 << ACT_W;
   localparam int STORE_N  = (NUM_ACTIONS < ACT_SPAN) ? NUM_ACTIONS : ACT_SPAN;
   localparam int IDX_W    = $clog2(STORE_N);
   localparam logic [ACT_W:0] ACT_LIMIT = (ACT_W + 1)'(STORE_N);
   localparam word_type ONE = word_type'(64'd1 << FRAC_BITS);

   word_type level_mem [STORE_N];
   word_type tick_mem  [STORE_N];

   logic [STORE_N-1:0] present_ff;
   logic               auth_ff;

   op_type             op_ff;
   logic [ACT_W-1:0]   act_ff;
   word_type           now_ff;
   word_type           rate_ff;
   word_type           burst_ff;
   word_type           cost_ff;
   word_type           level_rd_ff;
   word_type           tick_rd_ff;

   word_type           elapsed_ff;
   word_type           elapsed_in;
   dword_type          product_ff;
   word_type           refilled_ff;
   word_type           refilled_in;
   dword_type          sum;

   logic               rsp_valid_ff;
   logic               granted_ff;
   status_type         status_ff;
   word_type           left_ff;
   logic               granted_in;
   status_type         status_in;
   word_type           left_in;

   logic [IDX_W-1:0]   idx;
   logic [IDX_W-1:0]   req_idx;
   logic               in_range;
   logic               act_ok;
   logic               set_ok;
   logic               consume_go;
   logic               limited;
   word_type           final_level;
   logic               clear_one_hit;
   logic               clear_all_hit;

   assign req_idx  = req.action_id[IDX_W-1:0];
   assign idx      = act_ff[IDX_W-1:0];
   assign in_range = {1'b0, act_ff} < ACT_LIMIT;
   assign act_ok   = (act_ff != '0) && in_range;
   assign set_ok   = (rate_ff != '0) && (burst_ff >= ONE) && (cost_ff != '0);

   assign consume_go    = auth_ff && (op_ff == OP_CONSUME) && act_ok && set_ok;
   assign clear_one_hit = auth_ff && (op_ff == OP_CLEAR_ONE) && in_range;
   assign clear_all_hit = auth_ff && (op_ff == OP_CLEAR_ALL);

   assign sts.refill_path = consume_go && present_ff[idx];
   assign sts.rsp_free    = !rsp_valid_ff || rsp.ready;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         auth_ff <= 1'b1;
      end else if (csr.valid) begin
         auth_ff <= csr.has_authority;
      end
   end

   // request capture and table read
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff       <= op_type'(req.operation);
         act_ff      <= req.action_id;
         now_ff      <= req.now_tick;
         rate_ff     <= req.refill_rate;
         burst_ff    <= req.burst_capacity;
         cost_ff     <= req.cost;
         level_rd_ff <= level_mem[req_idx];
         tick_rd_ff  <= tick_mem[req_idx];
      end
   end

   assign elapsed_in = (now_ff > tick_rd_ff) ? now_ff - tick_rd_ff : '0;
   assign sum        = {{WORD_W{1'b0}}, level_rd_ff} + product_ff;

   always_comb begin
      refilled_in = refilled_ff;
      if (cmd.calc_elapsed) begin
         refilled_in = burst_ff;
      end else if (cmd.calc_sum) begin
         refilled_in = (sum > {{WORD_W{1'b0}}, burst_ff}) ? burst_ff : sum[WORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.calc_elapsed) elapsed_ff <= elapsed_in;
      if (cmd.calc_product) product_ff <= {{WORD_W{1'b0}}, elapsed_ff}
                                          * {{WORD_W{1'b0}}, rate_ff};
      refilled_ff <= refilled_in;
   end

   assign limited     = refilled_ff < cost_ff;
   assign final_level = limited ? refilled_ff : refilled_ff - cost_ff;

   always_comb begin
      granted_in = 1'b0;
      status_in  = ST_NO_AUTH;
      left_in    = '0;
      if (auth_ff) begin
         case (op_ff)
            OP_CONSUME: begin
               if (!act_ok) begin
                  status_in = ST_BAD_ACTION;
               end else if (!set_ok) begin
                  status_in = ST_BAD_SETTINGS;
               end else if (limited) begin
                  status_in = ST_LIMITED;
                  left_in   = refilled_ff;
               end else begin
                  granted_in = 1'b1;
                  status_in  = ST_OK;
                  left_in    = final_level;
               end
            end
            OP_CLEAR_ONE, OP_CLEAR_ALL: begin
               granted_in = 1'b1;
               status_in  = ST_OK;
            end
            default: begin
               status_in = ST_BAD_SETTINGS;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish && consume_go) begin
         level_mem[idx] <= final_level;
         tick_mem[idx]  <= now_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
      end else if (cmd.finish) begin
         if (clear_all_hit) begin
            present_ff <= '0;
         end else if (clear_one_hit) begin
            present_ff[idx] <= 1'b0;
         end else if (consume_go) begin
            present_ff[idx] <= 1'b1;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         granted_ff <= granted_in;
         status_ff  <= status_in;
         left_ff    <= left_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.granted     = granted_ff;
   assign rsp.status      = status_ff;
   assign rsp.tokens_left = left_ff;

   `KTBL_ASSERT_NEXT(a_finish_shows_rsp, clock, reset, cmd.finish, rsp_valid_ff)
   `KTBL_ASSERT_NEXT(a_consume_sets_bucket, clock, reset,
                     cmd.finish && consume_go, present_ff[idx])
   `KTBL_ASSERT_NEXT(a_clear_all_empties, clock, reset,
                     cmd.finish && clear_all_hit, present_ff == '0)

endmodule
